// ===== hdl/dhs_pkg.sv =====
// dhs_pkg: types, constants and register codes shared by the disk head scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none
package dhs_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int CYL_BITS_DEF    = 16;
    localparam int FIELD_W         = 16;
    localparam int DIST_W          = 22;
    localparam int TIME_W          = 48;
    localparam int ROOT_IN_W       = 32;
    localparam int ROOT_W          = 16;
    localparam int PADDR_W         = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_POLICY    = 3'd0;
    localparam logic [2:0] REG_HEAD      = 3'd1;
    localparam logic [2:0] REG_LOW_CYL   = 3'd2;
    localparam logic [2:0] REG_HIGH_CYL  = 3'd3;
    localparam logic [2:0] REG_SEEK_BASE = 3'd4;
    localparam logic [2:0] REG_SEEK_SCL  = 3'd5;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;

    typedef enum logic [2:0] {
        POL_FCFS   = 3'd0,
        POL_SSTF   = 3'd1,
        POL_SCAN   = 3'd2,
        POL_C_SCAN = 3'd3,
        POL_LOOK   = 3'd4,
        POL_C_LOOK = 3'd5
    } policy_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEED,
        ST_SETUP,
        ST_FETCH,
        ST_DIST,
        ST_ROOT,
        ST_MUL,
        ST_ACC,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] cylinder;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] served_cylinder;
        logic [FIELD_W-1:0] step_distance;
        logic [DIST_W-1:0]  total_distance;
        logic [TIME_W-1:0]  total_time;
        logic               served_valid;
        logic               overflowed;
        logic               last;
    } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/dhs_sort_cell.sv =====
// dhs_sort_cell: one cell of the insertion sort row; holds one cylinder.
// Depends on dhs_pkg. Instantiated in a row by disk_head_scheduler_core.
`default_nettype none
module dhs_sort_cell
    import dhs_pkg::*;
#(
    parameter int CYL_BITS = CYL_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                clr,
    input  wire logic                ins_en,
    input  wire logic [CYL_BITS-1:0] ins_val,
    input  wire logic                left_le,
    input  wire logic [CYL_BITS-1:0] left_val,
    input  wire logic                left_occ,
    output logic      [CYL_BITS-1:0] held_val,
    output logic                     held_occ,
    output logic                     le
);

    logic [CYL_BITS-1:0] val_reg;
    logic                occ_reg;

    assign held_val = val_reg;
    assign held_occ = occ_reg;
    // empty cells count as larger than anything
    assign le       = occ_reg && (val_reg <= ins_val);

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            occ_reg <= 1'b0;
        end else if (ins_en && !le) begin
            if (left_le) begin
                val_reg <= ins_val;
                occ_reg <= 1'b1;
            end else begin
                val_reg <= left_val;
                occ_reg <= left_occ;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dhs_root.sv =====
// dhs_root: iterative integer square root, one result bit per cycle.
// Depends on dhs_pkg. Used by disk_head_scheduler_core for seek time.
`default_nettype none
module dhs_root
    import dhs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [ROOT_IN_W-1:0] x,
    output logic                      done,
    output logic      [ROOT_W-1:0]    root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ROOT_IN_W-1:0] x_reg;
    logic [ROOT_W+1:0]    rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [ROOT_W+3:0]    rem_sh;
    logic [ROOT_W+3:0]    trial;
    logic                 fits;

    assign rem_sh = {rem_reg, x_reg[ROOT_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(ROOT_W - 1);
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            x_reg    <= {x_reg[ROOT_IN_W-3:0], 2'b00};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/disk_head_scheduler_core.sv =====
// disk_head_scheduler_core: top level of the disk head scheduler.
// Depends on dhs_pkg, dhs_sort_cell and dhs_root.
`default_nettype none
// Add items go into an arrival queue of QUEUE_DEPTH entries; an add on a full
// queue is dropped and raises the overflowed flag, which stays until reset. A
// run item feeds the queued cylinders (plus the high end cylinder for SCAN and
// both end cylinders for C_SCAN) into a row of QUEUE_DEPTH+2 insertion sort
// cells, one per cycle, then walks the order of the selected policy. Each result
// goes through a fetch, a distance step, the bit-serial square root for the seek
// time, a multiply and an accumulate; the accumulate waits until the output is
// free. SSTF adds up to one neighbor fetch per result, up to two for the first.
// A result may wait in the output register while the next one is computed. The
// block takes no item during a run.
module disk_head_scheduler_core
    import dhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CYL_BITS    = CYL_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int SD  = QUEUE_DEPTH + 2;
    localparam int CW  = $clog2(SD + 1);
    localparam int AW  = $clog2(SD);
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW  = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    logic [2:0]         policy_reg;
    logic [FIELD_W-1:0] head_reg, low_reg, high_reg, base_reg, scale_reg;
    logic [2:0]         reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 3'd0;
            head_reg   <= '0;
            low_reg    <= '0;
            high_reg   <= '1;
            base_reg   <= '0;
            scale_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POLICY:    policy_reg <= pwdata[2:0];
                REG_HEAD:      head_reg   <= pwdata[FIELD_W-1:0];
                REG_LOW_CYL:   low_reg    <= pwdata[FIELD_W-1:0];
                REG_HIGH_CYL:  high_reg   <= pwdata[FIELD_W-1:0];
                REG_SEEK_BASE: base_reg   <= pwdata[FIELD_W-1:0];
                REG_SEEK_SCL:  scale_reg  <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_POLICY:    prdata = {29'd0, policy_reg};
            REG_HEAD:      prdata = 32'(head_reg);
            REG_LOW_CYL:   prdata = 32'(low_reg);
            REG_HIGH_CYL:  prdata = 32'(high_reg);
            REG_SEEK_BASE: prdata = 32'(base_reg);
            REG_SEEK_SCL:  prdata = 32'(scale_reg);
            default:       prdata = '0;
        endcase
    end

    // control and datapath state
    state_t              state_reg, state_next;
    policy_t             mode_reg;
    logic [NW-1:0]       count_reg;
    logic                drop_reg;
    logic [CYL_BITS-1:0] arr_reg [QUEUE_DEPTH];
    logic [CYL_BITS-1:0] arr_rd_reg;
    logic [CW-1:0]       m_reg, s_reg, ptr_reg, lcnt_reg, rptr_reg, k_reg;
    logic                down_reg, need_l_reg, need_r_reg;
    logic [CYL_BITS-1:0] lval_reg, rval_reg, pos_reg, cyl_reg, dist_reg;
    logic [31:0]         prod_reg;
    logic [DIST_W-1:0]   dsum_reg;
    logic [TIME_W-1:0]   tsum_reg;
    out_item_t           out_reg;
    logic                m_valid_reg;

    logic [CYL_BITS-1:0] head, feed_val, sorted_rd, dist_c;
    logic [CW-1:0]       n_ext, m_calc, rd_idx, arr_addr;
    policy_t             mode_calc;
    logic                acc_run, acc_add, out_free, is_sstf, take_l, last_c;
    logic                arr_we, load_out;
    logic                root_done;
    logic [ROOT_W-1:0]   root_val;
    logic [32:0]         step_t;
    logic [TIME_W:0]     tsum_add;
    logic [DIST_W:0]     dsum_add;
    logic [TIME_W-1:0]   tsum_sat;
    logic [DIST_W-1:0]   dsum_sat;

    assign head     = head_reg[CYL_BITS-1:0];
    assign acc_run  = s_valid && s_ready && (s_data.req_type == REQ_RUN);
    assign acc_add  = s_valid && s_ready && (s_data.req_type == REQ_ADD);
    assign out_free = !m_valid_reg || m_ready;
    assign is_sstf  = (mode_reg == POL_SSTF);
    assign n_ext    = CW'(count_reg);
    assign last_c   = (k_reg + 1'b1) == m_reg;
    assign arr_we   = acc_add && (count_reg < NW'(QUEUE_DEPTH));
    assign load_out = out_free && (state_reg == ST_ACC || state_reg == ST_EMPTY);

    always_comb begin
        unique case (policy_reg)
            POL_SSTF:   mode_calc = POL_SSTF;
            POL_SCAN:   mode_calc = POL_SCAN;
            POL_C_SCAN: mode_calc = POL_C_SCAN;
            POL_LOOK:   mode_calc = POL_LOOK;
            POL_C_LOOK: mode_calc = POL_C_LOOK;
            default:    mode_calc = POL_FCFS;
        endcase
        unique case (mode_calc)
            POL_SCAN:   m_calc = n_ext + 1'b1;
            POL_C_SCAN: m_calc = n_ext + 2'd2;
            default:    m_calc = n_ext;
        endcase
    end

    // arrival queue read address; the read data is registered in arr_rd_reg, so the address runs ahead of ptr_reg
    always_comb begin
        unique case (state_reg)
            ST_FEED:  arr_addr = ptr_reg + 1'b1;
            ST_FETCH: arr_addr = (mode_reg == POL_FCFS) ? ptr_reg + 1'b1 : ptr_reg;
            ST_DIST, ST_ROOT, ST_MUL, ST_ACC: arr_addr = ptr_reg;
            default:  arr_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (arr_we) begin
            arr_reg[count_reg[QAW-1:0]] <= s_data.cylinder[CYL_BITS-1:0];
        end
        arr_rd_reg <= arr_reg[arr_addr[QAW-1:0]];
    end

    // sort row
    logic [CYL_BITS-1:0] cell_val [SD];
    logic                cell_occ [SD];
    logic                cell_le  [SD];
    logic                sort_clr, sort_ins;

    assign sort_clr = acc_run;
    assign sort_ins = (state_reg == ST_FEED);

    always_comb begin
        if (ptr_reg < n_ext) begin
            feed_val = arr_rd_reg;
        end else if (mode_reg == POL_C_SCAN && ptr_reg == n_ext) begin
            feed_val = low_reg[CYL_BITS-1:0];
        end else begin
            feed_val = high_reg[CYL_BITS-1:0];
        end
    end

    for (genvar i = 0; i < SD; i++) begin : g_cell
        logic                left_le, left_occ;
        logic [CYL_BITS-1:0] left_val;
        if (i == 0) begin : g_first
            assign left_le  = 1'b1;
            assign left_occ = 1'b0;
            assign left_val = '0;
        end else begin : g_rest
            assign left_le  = cell_le[i-1];
            assign left_occ = cell_occ[i-1];
            assign left_val = cell_val[i-1];
        end
        dhs_sort_cell #(.CYL_BITS(CYL_BITS)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clr      (sort_clr),
            .ins_en   (sort_ins),
            .ins_val  (feed_val),
            .left_le  (left_le),
            .left_val (left_val),
            .left_occ (left_occ),
            .held_val (cell_val[i]),
            .held_occ (cell_occ[i]),
            .le       (cell_le[i])
        );
    end

    // single read port on the sort row
    assign rd_idx    = is_sstf ? (need_l_reg ? lcnt_reg - 1'b1 : rptr_reg) : ptr_reg;
    assign sorted_rd = cell_val[rd_idx[AW-1:0]];

    assign take_l = (lcnt_reg != '0) &&
                    ((rptr_reg == m_reg) || ((pos_reg - lval_reg) <= (rval_reg - pos_reg)));
    assign dist_c = (cyl_reg > pos_reg) ? cyl_reg - pos_reg : pos_reg - cyl_reg;

    dhs_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_DIST),
        .x       ({FIELD_W'(dist_c), 16'd0}),
        .done    (root_done),
        .root    (root_val)
    );

    assign step_t   = 33'({base_reg, 8'd0}) + 33'(prod_reg);
    assign tsum_add = (TIME_W+1)'(tsum_reg) + (TIME_W+1)'(step_t);
    assign dsum_add = (DIST_W+1)'(dsum_reg) + (DIST_W+1)'(dist_reg);
    assign tsum_sat = tsum_add[TIME_W] ? TIME_MAX : tsum_add[TIME_W-1:0];
    assign dsum_sat = dsum_add[DIST_W] ? DIST_MAX : dsum_add[DIST_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (acc_run) state_next = (m_calc == '0) ? ST_EMPTY : ST_FEED;
            ST_FEED:  if (ptr_reg + 1'b1 == m_reg) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_FETCH;
            ST_FETCH: if (!is_sstf || (!need_l_reg && !need_r_reg)) state_next = ST_DIST;
            ST_DIST:  state_next = ST_ROOT;
            ST_ROOT:  if (root_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   if (out_free) state_next = last_c ? ST_IDLE : ST_FETCH;
            ST_EMPTY: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = m_valid_reg;
        m_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            if (acc_add) begin
                if (arr_we) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    drop_reg <= 1'b1;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (acc_run) begin
                        mode_reg <= mode_calc;
                        m_reg    <= m_calc;
                        s_reg    <= '0;
                        ptr_reg  <= '0;
                        dsum_reg <= '0;
                        tsum_reg <= '0;
                    end
                end
                ST_FEED: begin
                    if (feed_val <= head) s_reg <= s_reg + 1'b1;
                    ptr_reg <= ptr_reg + 1'b1;
                end
                ST_SETUP: begin
                    pos_reg    <= head;
                    k_reg      <= '0;
                    lcnt_reg   <= s_reg;
                    rptr_reg   <= s_reg;
                    need_l_reg <= (s_reg != '0);
                    need_r_reg <= (s_reg != m_reg);
                    down_reg   <= 1'b0;
                    unique case (mode_reg)
                        POL_FCFS: ptr_reg <= '0;
                        POL_SCAN, POL_LOOK: begin
                            // nothing above the head: go straight to the down sweep
                            down_reg <= (s_reg == m_reg);
                            ptr_reg  <= (s_reg == m_reg) ? s_reg - 1'b1 : s_reg;
                        end
                        default: ptr_reg <= (s_reg == m_reg) ? '0 : s_reg;
                    endcase
                end
                ST_FETCH: begin
                    if (is_sstf) begin
                        if (need_l_reg) begin
                            lval_reg   <= sorted_rd;
                            need_l_reg <= 1'b0;
                        end else if (need_r_reg) begin
                            rval_reg   <= sorted_rd;
                            need_r_reg <= 1'b0;
                        end else if (take_l) begin
                            cyl_reg    <= lval_reg;
                            lcnt_reg   <= lcnt_reg - 1'b1;
                            need_l_reg <= (lcnt_reg != CW'(1));
                        end else begin
                            cyl_reg    <= rval_reg;
                            rptr_reg   <= rptr_reg + 1'b1;
                            need_r_reg <= (rptr_reg + 1'b1 != m_reg);
                        end
                    end else begin
                        cyl_reg <= (mode_reg == POL_FCFS) ? arr_rd_reg : sorted_rd;
                        unique case (mode_reg)
                            POL_FCFS: ptr_reg <= ptr_reg + 1'b1;
                            POL_SCAN, POL_LOOK: begin
                                if (down_reg) begin
                                    ptr_reg <= ptr_reg - 1'b1;
                                end else if (ptr_reg + 1'b1 == m_reg) begin
                                    down_reg <= 1'b1;
                                    ptr_reg  <= s_reg - 1'b1;
                                end else begin
                                    ptr_reg <= ptr_reg + 1'b1;
                                end
                            end
                            default: ptr_reg <= (ptr_reg + 1'b1 == m_reg) ? '0 : ptr_reg + 1'b1;
                        endcase
                    end
                end
                ST_DIST: dist_reg <= dist_c;
                ST_ROOT: ;
                ST_MUL:  prod_reg <= 32'(scale_reg) * 32'(root_val);
                ST_ACC: begin
                    if (out_free) begin
                        dsum_reg <= dsum_sat;
                        tsum_reg <= tsum_sat;
                        out_reg  <= {FIELD_W'(cyl_reg), FIELD_W'(dist_reg), dsum_sat, tsum_sat,
                                     1'b1, drop_reg, last_c};
                        pos_reg  <= cyl_reg;
                        k_reg    <= k_reg + 1'b1;
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        out_reg <= {{(2*FIELD_W+DIST_W+TIME_W+1){1'b0}}, drop_reg, 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== tb/disk_head_scheduler_core_tb.sv =====
// disk_head_scheduler_core_tb: self-checking testbench of the disk head scheduler core.
// Depends on dhs_pkg and disk_head_scheduler_core; predicts every result with its own
// scheduler model and checks each result item as a whole.
`default_nettype none
module disk_head_scheduler_core_tb;
    import dhs_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int LMAX  = DEPTH + 2;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    disk_head_scheduler_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    logic [2:0]  cfg_policy;
    logic [15:0] cfg_head, cfg_low, cfg_high, cfg_base, cfg_scale;
    logic [15:0] req_queue [DEPTH];
    int          req_count;
    logic        dropped;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        mismatches = 0;
    int        in_accepts = 0;
    int        in_seen = 0;
    bit        hold_long = 1'b0;

    function automatic logic [15:0] isqrt32(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[15:0];
    endfunction

    // computes the results one item causes and queues them
    task automatic schedule_item(input in_item_t it);
        logic [15:0] lst [LMAX];
        logic [15:0] ord [LMAX];
        bit          used [LMAX];
        logic [15:0] tmp, pos, d, bd;
        logic [2:0]  mode;
        int          m, cnt, s, best;
        logic [22:0] dsum;
        logic [49:0] tsum;
        out_item_t   r;
        if (it.req_type == REQ_ADD) begin
            if (req_count < DEPTH) begin
                req_queue[req_count] = it.cylinder;
                req_count++;
            end else begin
                dropped = 1'b1;
            end
            return;
        end
        m = req_count;
        cnt = 0;
        mode = (cfg_policy > POL_C_LOOK) ? POL_FCFS : cfg_policy;
        for (int i = 0; i < m; i++) lst[i] = req_queue[i];
        if (mode == POL_SCAN) begin
            lst[m] = cfg_high;
            m++;
        end else if (mode == POL_C_SCAN) begin
            lst[m] = cfg_low;
            lst[m+1] = cfg_high;
            m += 2;
        end
        if (mode != POL_FCFS) begin
            for (int i = 1; i < m; i++) begin
                tmp = lst[i];
                s = i - 1;
                while (s >= 0 && lst[s] > tmp) begin
                    lst[s+1] = lst[s];
                    s--;
                end
                lst[s+1] = tmp;
            end
        end
        if (mode == POL_FCFS) begin
            for (int i = 0; i < m; i++) ord[cnt++] = lst[i];
        end else if (mode == POL_SSTF) begin
            pos = cfg_head;
            for (int i = 0; i < m; i++) used[i] = 0;
            for (int k = 0; k < m; k++) begin
                best = -1;
                bd = 0;
                for (int j = 0; j < m; j++) begin
                    if (!used[j]) begin
                        d = (lst[j] > pos) ? lst[j] - pos : pos - lst[j];
                        if (best < 0 || d < bd) begin
                            best = j;
                            bd = d;
                        end
                    end
                end
                used[best] = 1;
                pos = lst[best];
                ord[cnt++] = pos;
            end
        end else begin
            s = 0;
            while (s < m && lst[s] <= cfg_head) s++;
            if (mode == POL_SCAN || mode == POL_LOOK) begin
                for (int i = s; i < m; i++) ord[cnt++] = lst[i];
                for (int i = s - 1; i >= 0; i--) ord[cnt++] = lst[i];
            end else begin
                for (int i = 0; i < m; i++) ord[cnt++] = lst[(s + i) % m];
            end
        end
        if (cnt == 0) begin
            r = '0;
            r.overflowed = dropped;
            r.last = 1'b1;
            expected_results = {expected_results, r};
            return;
        end
        pos = cfg_head;
        dsum = 0;
        tsum = 0;
        for (int k = 0; k < cnt; k++) begin
            d = (ord[k] > pos) ? ord[k] - pos : pos - ord[k];
            dsum = dsum + d;
            if (dsum > DIST_MAX) dsum = DIST_MAX;
            tsum = tsum + ({34'd0, cfg_base} << 8)
                   + {34'd0, cfg_scale} * {34'd0, isqrt32({d, 16'd0})};
            if (tsum > TIME_MAX) tsum = TIME_MAX;
            r.served_cylinder = ord[k];
            r.step_distance = d;
            r.total_distance = dsum[21:0];
            r.total_time = tsum[47:0];
            r.served_valid = 1'b1;
            r.overflowed = dropped;
            r.last = (k == cnt - 1);
            expected_results = {expected_results, r};
            pos = ord[k];
        end
    endtask

    // items accepted at this edge go to the predictor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            schedule_item(s_data);
            in_accepts++;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_accepts != in_seen) begin
                in_seen = in_accepts;
                if (pending_items.size() > 0 && $urandom_range(0, 3) != 0) begin
                    s_data <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid && pending_items.size() > 0
                         && $urandom_range(0, 2) != 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
            end
            if (hold_long) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 1) == 1);
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %p", m_data);
            end else begin
                e = expected_results.pop_front();
                if (m_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, m_data);
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_POLICY:    cfg_policy = val[2:0];
            REG_HEAD:      cfg_head = val;
            REG_LOW_CYL:   cfg_low = val;
            REG_HIGH_CYL:  cfg_high = val;
            REG_SEEK_BASE: cfg_base = val;
            default:       cfg_scale = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic push_item(input logic t, input logic [15:0] c);
        in_item_t it;
        it.req_type = t;
        it.cylinder = c;
        pending_items = {pending_items, it};
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        repeat (g) @(negedge aclk);
    endtask

    initial begin
        int nadd;
        logic [15:0] cyl;
        cfg_policy = POL_FCFS;
        cfg_head = 0;
        cfg_low = 0;
        cfg_high = 16'hFFFF;
        cfg_base = 0;
        cfg_scale = 0;
        req_count = 0;
        dropped = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: run on an empty queue, then extremes under every policy
        push_item(REQ_RUN, 16'hFFFF);
        wait_drained();
        reg_write(REG_SEEK_BASE, 16'hFFFF);
        reg_write(REG_SEEK_SCL, 16'hFFFF);
        reg_write(REG_HEAD, 16'd100);
        reg_write(REG_LOW_CYL, 16'd0);
        reg_write(REG_HIGH_CYL, 16'hFFFF);
        push_item(REQ_ADD, 16'd0);
        push_item(REQ_ADD, 16'hFFFF);
        push_item(REQ_ADD, 16'd100);
        push_item(REQ_ADD, 16'd50);
        push_item(REQ_ADD, 16'd150);
        push_item(REQ_ADD, 16'd100);
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            reg_write(REG_POLICY, 16'(p));
            push_item(REQ_RUN, 16'd0);
        end
        wait_drained();
        // ties for the nearest search, and head at the top end
        reg_write(REG_POLICY, 16'(POL_SSTF));
        reg_write(REG_HEAD, 16'd75);
        push_item(REQ_RUN, 16'd0);
        wait_drained();
        reg_write(REG_POLICY, 16'(POL_C_SCAN));
        reg_write(REG_HEAD, 16'hFFFF);
        push_item(REQ_RUN, 16'd0);
        wait_drained();

        // random phases; queue keeps filling up to the drop point
        for (int ph = 0; ph < 16; ph++) begin
            reg_write(REG_POLICY, 16'($urandom_range(0, 7)));
            reg_write(REG_HEAD, (ph % 5 == 0) ? 16'd0 : 16'($urandom));
            reg_write(REG_LOW_CYL, (ph % 4 == 1) ? 16'hFFFF : 16'($urandom));
            reg_write(REG_HIGH_CYL, (ph % 4 == 2) ? 16'd0 : 16'($urandom));
            reg_write(REG_SEEK_BASE, (ph % 3 == 0) ? 16'hFFFF : 16'($urandom));
            reg_write(REG_SEEK_SCL, (ph % 3 == 1) ? 16'd0 : 16'($urandom));
            nadd = (req_count < DEPTH + 2) ? $urandom_range(0, 4) : 0;
            for (int i = 0; i < nadd; i++) begin
                cyl = ($urandom_range(0, 7) == 0) ? {16{$urandom_range(0, 1) == 1}}
                                                  : 16'($urandom);
                push_item(REQ_ADD, cyl);
                random_gap();
            end
            push_item(REQ_RUN, 16'($urandom));
            push_item(REQ_RUN, 16'($urandom));
            if (ph == 6) begin
                // receiver holds off long enough for the block to stall its input
                hold_long = 1'b1;
                repeat (400) @(negedge aclk);
                hold_long = 1'b0;
            end
            wait_drained();
        end
        // many extra adds and runs on a full queue
        for (int i = 0; i < 190; i++) begin
            if (i % 17 == 0) begin
                wait_drained();
                reg_write(REG_POLICY, 16'($urandom_range(0, 7)));
                reg_write(REG_HEAD, 16'($urandom));
            end
            push_item($urandom_range(0, 3) == 0 ? REQ_RUN : REQ_ADD, 16'($urandom));
            random_gap();
        end
        wait_drained();
        if (mismatches == 0) begin
            $display("disk_head_scheduler_core_tb: PASS");
        end else begin
            $display("disk_head_scheduler_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 1500000);
        $display("disk_head_scheduler_core_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
